// ----- hdl/pcft_pkg.sv -----
// Shared types, constants and scaling functions for the peer control frame tracker.
// No dependencies; every module in hdl/ imports this package.
package pcft_pkg;

   localparam int MaxFrameLenDefault = 255;

   // Byte counter saturates at all ones; the frame length needs one more bit.
   localparam int CountWidth = 9;
   localparam int LenWidth   = CountWidth + 1;
   localparam int SlotCount  = 8;
   localparam int SlotWidth  = $clog2(SlotCount);

   // Header bytes and frame types
   localparam logic [7:0] StartByte   = 8'hdb;
   localparam logic [7:0] TypeClear   = 8'he4;
   localparam logic [7:0] TypeVolume  = 8'hd2;
   localparam logic [7:0] TypeMic     = 8'hd3;
   localparam logic [7:0] TypeLegacy  = 8'hd4;
   localparam logic [7:0] TypeSummary = 8'h20;
   localparam logic [7:0] HeaderTag   = 8'd3;
   localparam logic [7:0] SummaryTag  = 8'd1;

   // Sub-codes in byte 4
   localparam logic [7:0] VolSubSet     = 8'd0;
   localparam logic [7:0] VolSubMax     = 8'd2;
   localparam logic [7:0] MicSubState   = 8'd1;
   localparam logic [7:0] MicSubLevel   = 8'd2;
   localparam logic [7:0] ClearSubFirst = 8'd1;
   localparam logic [7:0] ClearKeepAll  = 8'd3;

   // Frame lengths
   localparam int MinFrameLen   = 3;
   localparam int ShortFrameLen = 5;
   localparam int ValueFrameLen = 6;
   localparam int SummaryLen    = 46;

   // Value limits
   localparam logic [7:0] MaxStep     = 8'd56;
   localparam logic [7:0] MaxPercent  = 8'd100;
   localparam logic [7:0] MaxMicLevel = 8'd10;
   localparam logic [7:0] MinMicLevel = 8'd1;
   localparam logic [7:0] MaxMicState = 8'd1;
   localparam logic [7:0] MaxLegacy   = 8'd10;
   localparam int         MicScale    = 10;

   // Known-mask bit positions
   localparam int KnownVol = 0;
   localparam int KnownBal = 1;
   localparam int KnownMst = 2;
   localparam int KnownMlv = 3;
   localparam int KnownLeg = 4;
   localparam int KnownWidth = 5;

   // step*100/56 as multiply by reciprocal; exact for step <= 56
   localparam int ScaleShift = 20;
   localparam int VolRecip   = ((1 << ScaleShift) + 55) / 56;
   localparam int VolMul     = 100 * VolRecip;
   localparam int VolProdW   = 6 + $clog2(VolMul + 1);

   localparam logic [3:0][6:0] LegacyTable = {7'd100, 7'd50, 7'd25, 7'd0};

   typedef enum logic {
      OP_BYTE   = 1'b0,
      OP_NATIVE = 1'b1
   } op_type;

   typedef struct packed {
      logic [SlotCount-1:0][7:0] bytes;
      logic [LenWidth-1:0]       len;
   } frame_view_type;

   typedef struct packed {
      logic        accepted;
      logic [6:0]  volume_pct;
      logic [6:0]  balance_percent;
      logic        mic_muted_state;
      logic [6:0]  mic_lvl_scaled;
      logic [6:0]  legacy_scaled;
      logic [4:0]  known_mask;
      logic [31:0] change_generation;
      logic [31:0] mic_change_generation;
      logic [31:0] frame_count;
      logic [31:0] reject_count;
      logic [5:0]  loudness_now;
   } rsp_type;

   function automatic logic [6:0] volume_of(input logic [5:0] step);
      logic [VolProdW-1:0] prod;
      prod = VolProdW'(step) * VolProdW'(VolMul);
      return 7'(prod >> ScaleShift);
   endfunction

   function automatic logic [6:0] legacy_of(input logic [3:0] level);
      if (level < 4'd4) begin
         return LegacyTable[level[1:0]];
      end
      return 7'd0;
   endfunction

   function automatic logic [6:0] mic_scaled_of(input logic [3:0] level);
      logic [7:0] prod;
      prod = 8'(level) * 8'(MicScale);
      return prod[6:0];
   endfunction

endpackage

// ----- hdl/pcft_req_if.sv -----
// Input channel of the frame tracker: valid/ready plus one frame byte or native set.
// Standalone; widths follow the item fields.
interface pcft_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  frame_byte;
   logic        frame_last;
   logic [7:0]  native_step;
   logic [7:0]  native_balance;
   logic [31:0] now_ms;

   modport source (
      output valid, operation, frame_byte, frame_last, native_step, native_balance, now_ms,
      input  ready
   );
   modport sink (
      input  valid, operation, frame_byte, frame_last, native_step, native_balance, now_ms,
      output ready
   );
endinterface

// ----- hdl/pcft_rsp_if.sv -----
// Result channel of the frame tracker: valid/ready plus the status snapshot.
// Standalone; widths follow the result fields.
interface pcft_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [6:0]  volume_pct;
   logic [6:0]  balance_percent;
   logic        mic_muted_state;
   logic [6:0]  mic_lvl_scaled;
   logic [6:0]  legacy_scaled;
   logic [4:0]  known_mask;
   logic [31:0] change_generation;
   logic [31:0] mic_change_generation;
   logic [31:0] frame_count;
   logic [31:0] reject_count;
   logic [5:0]  loudness_now;

   modport source (
      output valid, accepted, volume_pct, balance_percent, mic_muted_state,
             mic_lvl_scaled, legacy_scaled, known_mask, change_generation,
             mic_change_generation, frame_count, reject_count, loudness_now,
      input  ready
   );
   modport sink (
      input  valid, accepted, volume_pct, balance_percent, mic_muted_state,
             mic_lvl_scaled, legacy_scaled, known_mask, change_generation,
             mic_change_generation, frame_count, reject_count, loudness_now,
      output ready
   );
endinterface

// ----- hdl/pcft_assembler.sv -----
// Byte counter and kept header/payload bytes; presents the frame with the current byte merged.
// Depends on pcft_pkg.
module pcft_assembler
   import pcft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     frame_byte,
   input  logic           frame_last,
   output frame_view_type view
);

   localparam logic [CountWidth-1:0] CountMax = '1;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            kept_ff [SlotCount];
   logic                  hit;
   logic [SlotWidth-1:0]  slot;

   // positions 0..5 map straight, 14 and 15 to the two top slots
   always_comb begin
      hit  = 1'b0;
      slot = '0;
      priority if (count_ff <= CountWidth'(5)) begin
         hit  = 1'b1;
         slot = SlotWidth'(count_ff);
      end else if (count_ff == CountWidth'(14)) begin
         hit  = 1'b1;
         slot = SlotWidth'(6);
      end else if (count_ff == CountWidth'(15)) begin
         hit  = 1'b1;
         slot = SlotWidth'(7);
      end else begin
         hit  = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < SlotCount; i++) begin
         view.bytes[i] = (hit && slot == SlotWidth'(i)) ? frame_byte : kept_ff[i];
      end
      view.len = LenWidth'(count_ff) + LenWidth'(1);
   end

   always_comb begin
      count_in = count_ff;
      if (advance) begin
         if (frame_last) begin
            count_in = '0;
         end else if (count_ff != CountMax) begin
            count_in = count_ff + CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hit) begin
         kept_ff[slot] <= frame_byte;
      end
   end

endmodule

// ----- hdl/pcft_tracker.sv -----
// Frame check and decode, tracked values, known mask, generation and frame counters.
// Depends on pcft_pkg; result is the snapshot after this item's update.
module pcft_tracker
   import pcft_pkg::*;
#(
   parameter int MAX_FRAME_LEN = MaxFrameLenDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           frame_done,
   input  logic           native_go,
   input  frame_view_type view,
   input  logic [7:0]     native_step,
   input  logic [7:0]     native_balance,
   output rsp_type        result
);

   logic [KnownWidth-1:0] known_ff, known_in;
   logic [31:0] gen_ff, gen_in, mic_gen_ff, mic_gen_in;
   logic [31:0] ok_cnt_ff, ok_cnt_in, bad_cnt_ff, bad_cnt_in;
   logic [5:0]  loud_ff, loud_in;
   logic [6:0]  vol_ff, vol_in, bal_ff, bal_in;
   logic        mst_ff, mst_in;
   logic [3:0]  mlv_ff, mlv_in, leg_ff, leg_in;

   logic [7:0] b [SlotCount];
   logic       well_formed, ok, bad, clear_known;
   logic       set_vol, set_bal, set_mst, set_mlv, set_leg;
   logic [5:0] vol_step;
   logic [6:0] vol_val, bal_val;
   logic       mst_val;
   logic [3:0] mlv_val, leg_val;
   logic       g_vol, g_bal, g_mst, g_mlv, g_leg, g_clr;
   logic [2:0] gen_step;

   always_comb begin
      for (int i = 0; i < SlotCount; i++) begin
         b[i] = view.bytes[i];
      end
      well_formed = view.len >= LenWidth'(MinFrameLen)
                 && view.len <= LenWidth'(MAX_FRAME_LEN)
                 && b[0] == StartByte
                 && LenWidth'(b[1]) == view.len;
   end

   // pick the action
   always_comb begin
      ok = 1'b0; bad = 1'b0; clear_known = 1'b0;
      set_vol = 1'b0; set_bal = 1'b0; set_mst = 1'b0; set_mlv = 1'b0; set_leg = 1'b0;
      vol_step = '0; bal_val = '0; mst_val = 1'b0; mlv_val = '0; leg_val = '0;
      if (native_go) begin
         if (native_step <= MaxStep && native_balance <= MaxPercent) begin
            ok       = 1'b1;
            set_vol  = 1'b1;
            vol_step = native_step[5:0];
            set_bal  = 1'b1;
            bal_val  = native_balance[6:0];
         end
      end else if (frame_done) begin
         if (!well_formed) begin
            bad = 1'b1;
         end else begin
            priority if (view.len == LenWidth'(ShortFrameLen) && b[2] == TypeClear
                  && b[3] == HeaderTag && b[4] >= ClearSubFirst && b[4] <= ClearKeepAll) begin
               ok          = 1'b1;
               clear_known = (b[4] != ClearKeepAll);
            end else if (view.len == LenWidth'(ValueFrameLen) && b[2] == TypeVolume
                  && b[3] == HeaderTag && b[4] <= VolSubMax) begin
               if (b[5] > MaxStep) begin
                  bad = 1'b1;
               end else begin
                  ok       = 1'b1;
                  set_vol  = (b[4] == VolSubSet);
                  vol_step = b[5][5:0];
               end
            end else if (view.len == LenWidth'(ValueFrameLen) && b[2] == TypeMic
                  && b[3] == HeaderTag && b[4] == MicSubState) begin
               if (b[5] > MaxMicState) begin
                  bad = 1'b1;
               end else begin
                  ok      = 1'b1;
                  set_mst = 1'b1;
                  mst_val = b[5][0];
               end
            end else if (view.len == LenWidth'(ValueFrameLen) && b[2] == TypeMic
                  && b[3] == HeaderTag && b[4] == MicSubLevel) begin
               if (b[5] < MinMicLevel || b[5] > MaxMicLevel) begin
                  bad = 1'b1;
               end else begin
                  ok      = 1'b1;
                  set_mlv = 1'b1;
                  mlv_val = b[5][3:0];
               end
            end else if (view.len == LenWidth'(ShortFrameLen) && b[2] == TypeLegacy
                  && b[3] == HeaderTag) begin
               if (b[4] > MaxLegacy) begin
                  bad = 1'b1;
               end else begin
                  ok      = 1'b1;
                  set_leg = 1'b1;
                  leg_val = b[4][3:0];
               end
            end else if (view.len == LenWidth'(SummaryLen) && b[2] == TypeSummary
                  && b[3] == SummaryTag) begin
               if (b[4] > MaxStep || b[6] > MaxMicState
                     || b[7] < MinMicLevel || b[7] > MaxMicLevel) begin
                  bad = 1'b1;
               end else begin
                  ok       = 1'b1;
                  set_vol  = 1'b1;
                  vol_step = b[4][5:0];
                  set_mst  = 1'b1;
                  mst_val  = b[6][0];
                  set_mlv  = 1'b1;
                  mlv_val  = b[7][3:0];
               end
            end else begin
               ok = 1'b0; // unknown type: no counters move
            end
         end
      end
   end

   // apply the action
   always_comb begin
      vol_val = volume_of(vol_step);
      g_vol = set_vol && (!known_ff[KnownVol] || vol_ff != vol_val);
      g_bal = set_bal && (!known_ff[KnownBal] || bal_ff != bal_val);
      g_mst = set_mst && (!known_ff[KnownMst] || mst_ff != mst_val);
      g_mlv = set_mlv && (!known_ff[KnownMlv] || mlv_ff != mlv_val);
      g_leg = set_leg && (!known_ff[KnownLeg] || leg_ff != leg_val);
      g_clr = clear_known && (known_ff[KnownLeg:KnownMst] != '0);
      gen_step = 3'(g_vol) + 3'(g_bal) + 3'(g_mst) + 3'(g_mlv) + 3'(g_leg) + 3'(g_clr);

      known_in = known_ff;
      if (clear_known) begin
         known_in = known_ff & KnownWidth'((1 << KnownVol) | (1 << KnownBal));
      end
      known_in[KnownVol] = known_in[KnownVol] | set_vol;
      known_in[KnownBal] = known_in[KnownBal] | set_bal;
      known_in[KnownMst] = known_in[KnownMst] | set_mst;
      known_in[KnownMlv] = known_in[KnownMlv] | set_mlv;
      known_in[KnownLeg] = known_in[KnownLeg] | set_leg;

      gen_in     = gen_ff + 32'(gen_step);
      mic_gen_in = mic_gen_ff + 32'(g_mst);
      ok_cnt_in  = ok_cnt_ff + 32'(frame_done && ok);
      bad_cnt_in = bad_cnt_ff + 32'(bad);
      loud_in    = set_vol ? vol_step : loud_ff;
      vol_in     = set_vol ? vol_val : vol_ff;
      bal_in     = set_bal ? bal_val : bal_ff;
      mst_in     = set_mst ? mst_val : mst_ff;
      mlv_in     = set_mlv ? mlv_val : mlv_ff;
      leg_in     = set_leg ? leg_val : leg_ff;
   end

   always_comb begin
      result.accepted              = ok;
      result.volume_pct            = vol_in;
      result.balance_percent       = bal_in;
      result.mic_muted_state       = mst_in;
      result.mic_lvl_scaled        = mic_scaled_of(mlv_in);
      result.legacy_scaled         = legacy_of(leg_in);
      result.known_mask            = known_in;
      result.change_generation     = gen_in;
      result.mic_change_generation = mic_gen_in;
      result.frame_count           = ok_cnt_in;
      result.reject_count          = bad_cnt_in;
      result.loudness_now          = loud_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff   <= '0;
         gen_ff     <= '0;
         mic_gen_ff <= '0;
         ok_cnt_ff  <= '0;
         bad_cnt_ff <= '0;
         loud_ff    <= '0;
         vol_ff     <= '0;
         bal_ff     <= '0;
         mst_ff     <= 1'b0;
         mlv_ff     <= '0;
         leg_ff     <= '0;
      end else if (frame_done || native_go) begin
         known_ff   <= known_in;
         gen_ff     <= gen_in;
         mic_gen_ff <= mic_gen_in;
         ok_cnt_ff  <= ok_cnt_in;
         bad_cnt_ff <= bad_cnt_in;
         loud_ff    <= loud_in;
         vol_ff     <= vol_in;
         bal_ff     <= bal_in;
         mst_ff     <= mst_in;
         mlv_ff     <= mlv_in;
         leg_ff     <= leg_in;
      end
   end

endmodule

// ----- hdl/peer_control_frame_tracker.sv -----
// Peer control frame tracker: input register, frame assembler, tracker, result register.
// Depends on pcft_pkg, pcft_req_if, pcft_rsp_if, pcft_assembler and pcft_tracker.
//
// Usage:
//  - req carries one frame byte per transfer (operation = 0) or a native
//    step/balance set (operation = 1). The byte with frame_last high closes
//    the frame and triggers the check and decode.
//  - rsp carries one status snapshot per closing byte and per native set;
//    middle bytes of a frame produce no transfer on rsp.
//  - Path: a req transfer loads the input register; its result is then
//    loaded into the result register, which drives rsp.valid.
//  - Throughput: one item per cycle while rsp does not stall. Each item
//    goes through one pass of check/decode/update logic between the input
//    register and the result register; the tracked state is written in that
//    same cycle, so the next item sees it at once.
//  - rsp stall: a finished result waits in the result register. Middle
//    bytes keep flowing; an item that owes a result waits in the input
//    register, and req.ready drops only while that register is held.
//  - Reset (synchronous, active high) clears counters, known mask and values,
//    and empties both registers. Kept frame bytes are not cleared.
module peer_control_frame_tracker
   import pcft_pkg::*;
#(
   parameter int MAX_FRAME_LEN = MaxFrameLenDefault
) (
   input logic       clock,
   input logic       reset,
   pcft_req_if.sink  req,
   pcft_rsp_if.source rsp
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   op_type     s1_op_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic [7:0] s1_step_ff;
   logic [7:0] s1_bal_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   logic           s1_has_rsp, out_free, s1_fire, req_fire;
   logic           frame_done, native_go, byte_go;
   frame_view_type view;
   rsp_type        result;

   assign s1_has_rsp = (s1_op_ff == OP_NATIVE) || s1_last_ff;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign s1_fire    = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req.ready  = !s1_valid_ff || s1_fire;
   assign req_fire   = req.valid && req.ready;

   assign byte_go    = s1_fire && (s1_op_ff == OP_BYTE);
   assign frame_done = byte_go && s1_last_ff;
   assign native_go  = s1_fire && (s1_op_ff == OP_NATIVE);

   pcft_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .advance    (byte_go),
      .frame_byte (s1_byte_ff),
      .frame_last (s1_last_ff),
      .view       (view)
   );

   pcft_tracker #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .frame_done     (frame_done),
      .native_go      (native_go),
      .view           (view),
      .native_step    (s1_step_ff),
      .native_balance (s1_bal_ff),
      .result         (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= op_type'(req.operation);
         s1_byte_ff <= req.frame_byte;
         s1_last_ff <= req.frame_last;
         s1_step_ff <= req.native_step;
         s1_bal_ff  <= req.native_balance;
      end
      if (s1_fire && s1_has_rsp) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid                 = rsp_valid_ff;
   assign rsp.accepted              = rsp_ff.accepted;
   assign rsp.volume_pct            = rsp_ff.volume_pct;
   assign rsp.balance_percent       = rsp_ff.balance_percent;
   assign rsp.mic_muted_state       = rsp_ff.mic_muted_state;
   assign rsp.mic_lvl_scaled        = rsp_ff.mic_lvl_scaled;
   assign rsp.legacy_scaled         = rsp_ff.legacy_scaled;
   assign rsp.known_mask            = rsp_ff.known_mask;
   assign rsp.change_generation     = rsp_ff.change_generation;
   assign rsp.mic_change_generation = rsp_ff.mic_change_generation;
   assign rsp.frame_count           = rsp_ff.frame_count;
   assign rsp.reject_count          = rsp_ff.reject_count;
   assign rsp.loudness_now          = rsp_ff.loudness_now;

`ifndef NO_ASSERTIONS
   // an empty input register always takes a new transfer
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("req.ready low with empty input register");

   // a taken result that is not replaced must not show up again
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !(s1_fire && s1_has_rsp) |=> !rsp.valid)
      else $error("result delivered twice");

   // a held result blocks any item that owes a result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready && s1_valid_ff && s1_has_rsp |-> !s1_fire)
      else $error("pending result overwritten");
`endif

endmodule

// ----- tb/sv/pcft_tb_pkg.sv -----
// Checker for the peer control frame tracker: item type, byte queue type and a
// class that tracks the block state, predicts each status snapshot and checks it.
// Depends on pcft_pkg.
package pcft_tb_pkg;
   import pcft_pkg::*;

   // Frame positions that the decoder keeps: 0..5 and the two tail bytes
   localparam int HeadBytes  = 6;
   localparam int TailPos    = 14;
   localparam int MaxReports = 10;

   typedef logic [7:0] byte_queue_t[$];

   typedef struct packed {
      op_type      operation;
      logic [7:0]  frame_byte;
      logic        frame_last;
      logic [7:0]  native_step;
      logic [7:0]  native_balance;
      logic [31:0] now_ms;
   } tracker_item_t;

   class status_tracker_check;
      rsp_type     expected_snapshots[$];
      int unsigned mismatches;
      int unsigned results_due;

      logic [CountWidth-1:0] byte_count;
      logic [7:0]            kept [SlotCount];
      logic [KnownWidth-1:0] known;
      logic [31:0]           gen_count;
      logic [31:0]           mic_gen_count;
      logic [31:0]           ok_count;
      logic [31:0]           bad_count;
      logic [5:0]            loudness;
      logic [6:0]            volume;
      logic [6:0]            balance;
      logic                  mute_flag;
      logic [3:0]            mic_lvl;
      logic [3:0]            legacy;

      function new();
         mismatches    = 0;
         results_due   = 0;
         byte_count    = '0;
         foreach (kept[i]) kept[i] = '0;
         known         = '0;
         gen_count     = '0;
         mic_gen_count = '0;
         ok_count      = '0;
         bad_count     = '0;
         loudness      = '0;
         volume        = '0;
         balance       = '0;
         mute_flag     = 1'b0;
         mic_lvl       = '0;
         legacy        = '0;
      endfunction

      // first setting or a new value counts as a change
      function void mark(int kb, bit differs);
         if (!known[kb] || differs) gen_count++;
         known[kb] = 1'b1;
      endfunction

      function void apply_step(logic [7:0] step);
         logic [6:0] pct;
         pct = 7'((32'(step) * 100) / 56);
         loudness = step[5:0];
         mark(KnownVol, volume != pct);
         volume = pct;
      endfunction

      function void apply_mic(logic st);
         if (!known[KnownMst] || mute_flag != st) mic_gen_count++;
         mark(KnownMst, mute_flag != st);
         mute_flag = st;
      endfunction

      function void apply_level(logic [7:0] lv);
         mark(KnownMlv, mic_lvl != lv[3:0]);
         mic_lvl = lv[3:0];
      endfunction

      function void apply_legacy(logic [7:0] lv);
         mark(KnownLeg, legacy != lv[3:0]);
         legacy = lv[3:0];
      endfunction

      function bit decode_frame(int unsigned n);
         logic [KnownWidth-1:0] keep;
         if (n < MinFrameLen || n > MaxFrameLenDefault || kept[0] != StartByte ||
             32'(kept[1]) != n) begin
            bad_count++;
            return 1'b0;
         end
         if (n == ShortFrameLen && kept[2] == TypeClear && kept[3] == HeaderTag &&
             kept[4] >= ClearSubFirst && kept[4] <= ClearKeepAll) begin
            if (kept[4] != ClearKeepAll) begin
               keep = known & KnownWidth'((1 << KnownVol) | (1 << KnownBal));
               if (keep != known) gen_count++;
               known = keep;
            end
         end else if (n == ValueFrameLen && kept[2] == TypeVolume && kept[3] == HeaderTag &&
                      kept[4] <= VolSubMax) begin
            if (kept[5] > MaxStep) begin
               bad_count++;
               return 1'b0;
            end
            if (kept[4] == VolSubSet) apply_step(kept[5]);
         end else if (n == ValueFrameLen && kept[2] == TypeMic && kept[3] == HeaderTag &&
                      kept[4] == MicSubState) begin
            if (kept[5] > MaxMicState) begin
               bad_count++;
               return 1'b0;
            end
            apply_mic(kept[5][0]);
         end else if (n == ValueFrameLen && kept[2] == TypeMic && kept[3] == HeaderTag &&
                      kept[4] == MicSubLevel) begin
            if (kept[5] < MinMicLevel || kept[5] > MaxMicLevel) begin
               bad_count++;
               return 1'b0;
            end
            apply_level(kept[5]);
         end else if (n == ShortFrameLen && kept[2] == TypeLegacy && kept[3] == HeaderTag) begin
            if (kept[4] > MaxLegacy) begin
               bad_count++;
               return 1'b0;
            end
            apply_legacy(kept[4]);
         end else if (n == SummaryLen && kept[2] == TypeSummary && kept[3] == SummaryTag) begin
            if (kept[4] > MaxStep || kept[6] > MaxMicState ||
                kept[7] < MinMicLevel || kept[7] > MaxMicLevel) begin
               bad_count++;
               return 1'b0;
            end
            apply_step(kept[4]);
            apply_mic(kept[6][0]);
            apply_level(kept[7]);
         end else begin
            return 1'b0;
         end
         ok_count++;
         return 1'b1;
      endfunction

      function void push_snapshot(bit ok);
         rsp_type s;
         s.accepted         = ok;
         s.volume_pct       = volume;
         s.balance_percent  = balance;
         s.mic_muted_state  = mute_flag;
         s.mic_lvl_scaled   = 7'(mic_lvl * 10);
         case (legacy)
            4'd0:    s.legacy_scaled = 7'd0;
            4'd1:    s.legacy_scaled = 7'd25;
            4'd2:    s.legacy_scaled = 7'd50;
            4'd3:    s.legacy_scaled = 7'd100;
            default: s.legacy_scaled = 7'd0;
         endcase
         s.known_mask            = known;
         s.change_generation     = gen_count;
         s.mic_change_generation = mic_gen_count;
         s.frame_count           = ok_count;
         s.reject_count          = bad_count;
         s.loudness_now          = loudness;
         expected_snapshots.push_back(s);
         results_due++;
      endfunction

      function void note_item(tracker_item_t it);
         int unsigned pos;
         bit ok;
         if (it.operation == OP_NATIVE) begin
            ok = (it.native_step <= MaxStep) && (it.native_balance <= MaxPercent);
            if (ok) begin
               apply_step(it.native_step);
               mark(KnownBal, balance != it.native_balance[6:0]);
               balance = it.native_balance[6:0];
            end
            push_snapshot(ok);
            return;
         end
         pos = 32'(byte_count);
         if (pos < HeadBytes) kept[pos] = it.frame_byte;
         else if (pos == TailPos) kept[HeadBytes] = it.frame_byte;
         else if (pos == TailPos + 1) kept[HeadBytes + 1] = it.frame_byte;
         if (byte_count != '1) byte_count++;
         if (!it.frame_last) return;
         byte_count = '0;
         push_snapshot(decode_frame(pos + 1));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_snapshot(rsp_type got);
         rsp_type want;
         if (expected_snapshots.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("result with nothing expected: frame_count %0d, reject_count %0d",
                        got.frame_count, got.reject_count);
            return;
         end
         want = expected_snapshots.pop_front();
         compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
         compare_field("volume_pct", 32'(want.volume_pct), 32'(got.volume_pct));
         compare_field("balance_percent", 32'(want.balance_percent),
                       32'(got.balance_percent));
         compare_field("mic_muted_state", 32'(want.mic_muted_state),
                       32'(got.mic_muted_state));
         compare_field("mic_lvl_scaled", 32'(want.mic_lvl_scaled), 32'(got.mic_lvl_scaled));
         compare_field("legacy_scaled", 32'(want.legacy_scaled), 32'(got.legacy_scaled));
         compare_field("known_mask", 32'(want.known_mask), 32'(got.known_mask));
         compare_field("change_generation", want.change_generation, got.change_generation);
         compare_field("mic_change_generation", want.mic_change_generation,
                       got.mic_change_generation);
         compare_field("frame_count", want.frame_count, got.frame_count);
         compare_field("reject_count", want.reject_count, got.reject_count);
         compare_field("loudness_now", 32'(want.loudness_now), 32'(got.loudness_now));
      endfunction

      function int pending();
         return expected_snapshots.size();
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_peer_control_frame_tracker.sv -----
// Top of the frame tracker testbench: clock, reset, stimulus and result sink.
// Feeds directed then random frames and native sets, checks every status snapshot.
// Depends on pcft_pkg, pcft_tb_pkg, pcft_req_if, pcft_rsp_if and the tracker RTL.
module tb_peer_control_frame_tracker;
   import pcft_pkg::*;
   import pcft_tb_pkg::*;

   localparam int          ItemTarget    = 1300;
   localparam int          ResultsWanted = 60;
   localparam int          MaxWait       = 12;
   // extra wait after the last expected result catches strays
   localparam int          DrainCycles   = 8;
   // watchdog limit for the run, with room for the long frames
   localparam int unsigned CycleLimit    = 400000;

   typedef enum int {
      FK_VOLUME,
      FK_MIC_STATE,
      FK_MIC_LEVEL,
      FK_LEGACY,
      FK_CLEAR,
      FK_SUMMARY
   } frame_kind_t;

   logic        clock;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   bit          steady = 1'b0;   // set: neither side idles
   status_tracker_check status_check;

   pcft_req_if req_bus ();
   pcft_rsp_if rsp_bus ();

   peer_control_frame_tracker uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop if the handshakes ever hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Per-item idle draw shared by both sides; steady stretches run back to back.
   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, MaxWait);
   endfunction

   // Value inside [lo, hi], or outside it with the given chance in percent.
   function automatic logic [7:0] pick(input int lo, input int hi, input int miss_pct);
      logic [7:0] v;
      if ($urandom_range(0, 99) >= miss_pct || (lo == 0 && hi == 255))
         return 8'($urandom_range(lo, hi));
      do v = 8'($urandom); while (v >= lo && v <= hi);
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Frame builders
   // ---------------------------------------------------------------------
   // Start byte, length byte (low 8 bits of len), kind, tag, random filler.
   function automatic byte_queue_t head_frame(input logic [7:0] kind, input logic [7:0] tag,
                                              input int len);
      byte_queue_t f;
      f.push_back(StartByte);
      if (len > 1) f.push_back(8'(len));
      for (int i = 2; i < len; i++) f.push_back(8'($urandom));
      if (len > 2) f[2] = kind;
      if (len > 3) f[3] = tag;
      return f;
   endfunction

   function automatic byte_queue_t short_frame(input logic [7:0] kind, input logic [7:0] tag,
                                               input logic [7:0] b4);
      byte_queue_t f;
      f = head_frame(kind, tag, ShortFrameLen);
      f[4] = b4;
      return f;
   endfunction

   function automatic byte_queue_t value_frame(input logic [7:0] kind, input logic [7:0] tag,
                                               input logic [7:0] b4, input logic [7:0] b5);
      byte_queue_t f;
      f = head_frame(kind, tag, ValueFrameLen);
      f[4] = b4;
      f[5] = b5;
      return f;
   endfunction

   // Summary: step at byte 4, mic state and level in the two tail bytes.
   function automatic byte_queue_t summary_frame(input logic [7:0] step, input logic [7:0] st,
                                                 input logic [7:0] level);
      byte_queue_t f;
      f = head_frame(TypeSummary, SummaryTag, SummaryLen);
      f[4]           = step;
      f[TailPos]     = st;
      f[TailPos + 1] = level;
      return f;
   endfunction

   function automatic byte_queue_t noise_frame(input int len);
      byte_queue_t f;
      for (int i = 0; i < len; i++) f.push_back(8'($urandom));
      return f;
   endfunction

   // Well-formed frame of one type, payload mostly in range.
   function automatic byte_queue_t typed_frame(input frame_kind_t kind);
      int r;
      logic [7:0] sub;
      r = $urandom_range(0, 99);
      case (kind)
         FK_VOLUME: begin
            if (r < 70) sub = VolSubSet;
            else if (r < 90) sub = 8'($urandom_range(1, VolSubMax));
            else sub = 8'($urandom);
            return value_frame(TypeVolume, HeaderTag, sub, pick(0, MaxStep, 15));
         end
         FK_MIC_STATE:
            return value_frame(TypeMic, HeaderTag, MicSubState, pick(0, MaxMicState, 10));
         FK_MIC_LEVEL:
            return value_frame(TypeMic, HeaderTag, MicSubLevel,
                               pick(MinMicLevel, MaxMicLevel, 15));
         FK_LEGACY:
            return short_frame(TypeLegacy, HeaderTag, pick(0, MaxLegacy, 15));
         FK_CLEAR: begin
            sub = (r < 85) ? 8'($urandom_range(ClearSubFirst, ClearKeepAll)) : 8'($urandom);
            return short_frame(TypeClear, HeaderTag, sub);
         end
         default:
            return summary_frame(pick(0, MaxStep, 10), pick(0, MaxMicState, 10),
                                 pick(MinMicLevel, MaxMicLevel, 10));
      endcase
   endfunction

   function automatic frame_kind_t pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return FK_VOLUME;
      if (r < 42) return FK_MIC_STATE;
      if (r < 57) return FK_MIC_LEVEL;
      if (r < 72) return FK_LEGACY;
      if (r < 86) return FK_CLEAR;
      return FK_SUMMARY;
   endfunction

   // Broken framing: bad start, bad length byte, truncated, padded or junk.
   function automatic byte_queue_t broken_frame();
      byte_queue_t f;
      logic [7:0]  v;
      f = typed_frame(frame_kind_t'($urandom_range(FK_VOLUME, FK_CLEAR)));
      case ($urandom_range(0, 5))
         0: begin
            do v = 8'($urandom); while (v == StartByte);
            f[0] = v;
         end
         1: f[1] = f[1] + 8'($urandom_range(1, 255));
         2: void'(f.pop_back());
         3: f.push_back(8'($urandom));
         4: f = noise_frame($urandom_range(1, 2));
         default: f = noise_frame($urandom_range(3, 20));
      endcase
      return f;
   endfunction

   // Correct start and length byte, random type and tag: mostly unknown types.
   function automatic byte_queue_t odd_type_frame();
      int len;
      len = ($urandom_range(0, 19) == 0) ? MaxFrameLenDefault : $urandom_range(MinFrameLen, 12);
      return head_frame(8'($urandom), 8'($urandom), len);
   endfunction

   // Past the length limit; now and then past the byte counter's saturation.
   function automatic byte_queue_t oversize_frame();
      byte_queue_t f;
      int len;
      if ($urandom_range(0, 4) == 0) len = $urandom_range(512, 530);
      else len = $urandom_range(MaxFrameLenDefault + 1, 300);
      f = head_frame(8'($urandom), 8'($urandom), len);
      f[1] = 8'($urandom);
      return f;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // valid goes low only across a drawn gap, so back-to-back items keep it high.
   task automatic push_item(input tracker_item_t it);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= it.operation;
      req_bus.frame_byte     <= it.frame_byte;
      req_bus.frame_last     <= it.frame_last;
      req_bus.native_step    <= it.native_step;
      req_bus.native_balance <= it.native_balance;
      req_bus.now_ms         <= it.now_ms;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      status_check.note_item(it);
      items_sent++;
   endtask

   // native fields are don't-care on a byte transfer; randomize them anyway
   task automatic send_byte(input logic [7:0] value, input logic last);
      tracker_item_t it;
      it.operation      = OP_BYTE;
      it.frame_byte     = value;
      it.frame_last     = last;
      it.native_step    = 8'($urandom);
      it.native_balance = 8'($urandom);
      it.now_ms         = $urandom;
      push_item(it);
   endtask

   task automatic send_native(input logic [7:0] step, input logic [7:0] bal);
      tracker_item_t it;
      it.operation      = OP_NATIVE;
      it.frame_byte     = 8'($urandom);
      it.frame_last     = 1'($urandom);
      it.native_step    = step;
      it.native_balance = bal;
      it.now_ms         = $urandom;
      push_item(it);
   endtask

   // native_pct: chance of a native set slipped in ahead of each byte after the first
   task automatic send_frame(input byte_queue_t bytes, input int native_pct);
      foreach (bytes[i]) begin
         if (i > 0 && $urandom_range(0, 99) < native_pct)
            send_native(pick(0, MaxStep, 15), pick(0, MaxPercent, 15));
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   task automatic send_random_frame();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) send_frame(typed_frame(pick_kind()), 3);
      else if (roll < 72) send_native(pick(0, MaxStep, 15), pick(0, MaxPercent, 15));
      else if (roll < 86) send_frame(broken_frame(), 3);
      else if (roll < 99) send_frame(odd_type_frame(), 3);
      else send_frame(oversize_frame(), 0);
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall drawn per result, snapshot checked on each transfer
   // ---------------------------------------------------------------------
   initial begin
      rsp_type got;
      int stall;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.accepted              = rsp_bus.accepted;
         got.volume_pct            = rsp_bus.volume_pct;
         got.balance_percent       = rsp_bus.balance_percent;
         got.mic_muted_state       = rsp_bus.mic_muted_state;
         got.mic_lvl_scaled        = rsp_bus.mic_lvl_scaled;
         got.legacy_scaled         = rsp_bus.legacy_scaled;
         got.known_mask            = rsp_bus.known_mask;
         got.change_generation     = rsp_bus.change_generation;
         got.mic_change_generation = rsp_bus.mic_change_generation;
         got.frame_count           = rsp_bus.frame_count;
         got.reject_count          = rsp_bus.reject_count;
         got.loudness_now          = rsp_bus.loudness_now;
         status_check.check_snapshot(got);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      byte_queue_t f;
      status_check = new();
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= OP_BYTE;
      req_bus.frame_byte     <= '0;
      req_bus.frame_last     <= 1'b0;
      req_bus.native_step    <= '0;
      req_bus.native_balance <= '0;
      req_bus.now_ms         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // native set: extremes, each limit just crossed, all ones
      send_native(8'd0, 8'd0);
      send_native(MaxStep, MaxPercent);
      send_native(MaxStep + 8'd1, 8'd50);
      send_native(8'd20, MaxPercent + 8'd1);
      send_native(8'hff, 8'hff);

      // volume: both ends, over range, a no-op sub-code, an unknown sub-code
      send_frame(value_frame(TypeVolume, HeaderTag, VolSubSet, 8'd0), 0);
      send_frame(value_frame(TypeVolume, HeaderTag, VolSubSet, MaxStep), 0);
      send_frame(value_frame(TypeVolume, HeaderTag, VolSubMax, MaxStep + 8'd1), 0);
      send_frame(value_frame(TypeVolume, HeaderTag, VolSubMax, 8'd9), 0);
      send_frame(value_frame(TypeVolume, HeaderTag, VolSubMax + 8'd1, 8'd9), 0);

      // mic state and level, in range and out
      send_frame(value_frame(TypeMic, HeaderTag, MicSubState, MaxMicState), 0);
      send_frame(value_frame(TypeMic, HeaderTag, MicSubState, MaxMicState + 8'd1), 0);
      send_frame(value_frame(TypeMic, HeaderTag, MicSubLevel, MaxMicLevel), 0);
      send_frame(value_frame(TypeMic, HeaderTag, MicSubLevel, MinMicLevel - 8'd1), 0);
      send_frame(value_frame(TypeMic, HeaderTag, MicSubLevel, MaxMicLevel + 8'd1), 0);

      // legacy: top table entry, level past the table, over range
      send_frame(short_frame(TypeLegacy, HeaderTag, 8'd3), 0);
      send_frame(short_frame(TypeLegacy, HeaderTag, MaxLegacy), 0);
      send_frame(short_frame(TypeLegacy, HeaderTag, MaxLegacy + 8'd1), 0);

      // clear-known: keep-all, a real clear, an unknown sub-code
      send_frame(short_frame(TypeClear, HeaderTag, ClearKeepAll), 0);
      send_frame(short_frame(TypeClear, HeaderTag, ClearSubFirst), 0);
      send_frame(short_frame(TypeClear, HeaderTag, 8'd0), 0);

      // summary: accepted, then rejected on mic level
      send_frame(summary_frame(MaxStep, MaxMicState, MaxMicLevel), 0);
      send_frame(summary_frame(8'd0, 8'd0, MinMicLevel - 8'd1), 0);

      // framing: too short, bad start, bad length byte
      send_frame(noise_frame(1), 0);
      send_frame(noise_frame(2), 0);
      f = short_frame(TypeLegacy, HeaderTag, 8'd1);
      f[0] = ~StartByte;
      send_frame(f, 0);
      f = short_frame(TypeLegacy, HeaderTag, 8'd1);
      f[1] = 8'(ShortFrameLen - 1);
      send_frame(f, 0);

      // longest legal frame (unknown type), one past it, counter saturation
      send_frame(head_frame(8'h55, 8'h55, MaxFrameLenDefault), 0);
      send_frame(head_frame(TypeSummary, SummaryTag, MaxFrameLenDefault + 1), 0);
      send_frame(head_frame(TypeSummary, SummaryTag, 520), 0);

      // native sets between every byte of a frame must not disturb it
      send_frame(value_frame(TypeMic, HeaderTag, MicSubState, 8'd0), 100);

      // random part: mostly well-formed frames, some noise and broken ones
      while (items_sent < ItemTarget || status_check.results_due < ResultsWanted) begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         send_random_frame();
      end
      req_bus.valid <= 1'b0;

      while (status_check.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (status_check.mismatches == 0 && status_check.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
